### rtl/bsmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmh_pkg: shared types, constants and round functions
// Job format between the front end and the back end, word packing, and one
// round of the mix and of the final scramble.
// ----------------------------------------------------------------------------
package bsmh_pkg;

  localparam int GROUP_LEN   = 12;
  localparam int POS_W       = $clog2(GROUP_LEN + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_W      = 3;

  localparam logic [STEP_W-1:0] MIX_LAST = STEP_W'(5);
  localparam logic [STEP_W-1:0] FIN_LAST = STEP_W'(6);

  localparam logic [31:0] INIT_A = 32'h9e37_79b9;
  localparam logic [31:0] INIT_B = 32'h9e37_79b9;
  localparam logic [31:0] INIT_C = 32'd3923095;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  // One unit of back-end work: a full group to mix, a tail to finish, or a
  // full group followed by an empty tail.
  typedef struct packed {
    logic [GROUP_LEN-1:0][7:0] bytes;
    logic [POS_W-1:0]          count;
    logic                      do_mix;
    logic                      do_fin;
    logic                      big_endian;
  } job_t;

  localparam words_t INIT_WORDS = '{a: INIT_A, b: INIT_B, c: INIT_C};

  function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // Bytes land in disjoint byte lanes, so OR is the same as the add.
  function automatic words_t pack_words(input job_t job);
    logic [2:0][31:0] w;
    logic [5:0]       sh;
    w  = '0;
    sh = '0;
    for (int i = 0; i < GROUP_LEN; i++) begin
      if (job.do_mix || (POS_W'(i) < job.count)) begin
        if (job.big_endian) begin
          sh = 6'(24 - 8 * (i % 4));
        end else begin
          sh = 6'(8 * (i % 4) + ((!job.do_mix && i >= 8) ? 8 : 0));
        end
        w[i/4] = w[i/4] | (32'(job.bytes[i]) << sh);
      end
    end
    return '{a: w[0], b: w[1], c: w[2]};
  endfunction

  function automatic words_t mix_step(input words_t w, input logic [STEP_W-1:0] step);
    words_t r;
    r = w;
    case (step)
      3'd0: begin r.a = (w.a - w.c) ^ rotl(w.c, 4);  r.c = w.c + w.b; end
      3'd1: begin r.b = (w.b - w.a) ^ rotl(w.a, 6);  r.a = w.a + w.c; end
      3'd2: begin r.c = (w.c - w.b) ^ rotl(w.b, 8);  r.b = w.b + w.a; end
      3'd3: begin r.a = (w.a - w.c) ^ rotl(w.c, 16); r.c = w.c + w.b; end
      3'd4: begin r.b = (w.b - w.a) ^ rotl(w.a, 19); r.a = w.a + w.c; end
      3'd5: begin r.c = (w.c - w.b) ^ rotl(w.b, 4);  r.b = w.b + w.a; end
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic words_t final_step(input words_t w, input logic [STEP_W-1:0] step);
    words_t r;
    r = w;
    case (step)
      3'd0: r.c = (w.c ^ w.b) - rotl(w.b, 14);
      3'd1: r.a = (w.a ^ w.c) - rotl(w.c, 11);
      3'd2: r.b = (w.b ^ w.a) - rotl(w.a, 25);
      3'd3: r.c = (w.c ^ w.b) - rotl(w.b, 16);
      3'd4: r.a = (w.a ^ w.c) - rotl(w.c, 4);
      3'd5: r.b = (w.b ^ w.a) - rotl(w.a, 14);
      3'd6: r.c = (w.c ^ w.b) - rotl(w.b, 24);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

### rtl/byte_stream_mix_hash.sv
`timescale 1ns / 1ps
// Intake: one key byte per cycle, sustained, while the job queue has room.
// A full group of twelve bytes costs the back end an add and six mix rounds.
// A short key's end job is added, then runs the seven final rounds into the output
// register; a key that closes on a full group runs the six mix rounds in between.
// Engine: one round per cycle, the last waiting on a held hash; jobs run one at a time.
// rst_n is synchronous, active low: state words reload, order resets to little-endian.
// ----------------------------------------------------------------------------
// byte_stream_mix_hash: streaming 32-bit byte-key hash
// Front end packs bytes into twelve-byte groups; a two-entry job queue feeds a
// round-per-cycle mixing engine (barring a held hash) that delivers the hash per key.
// ----------------------------------------------------------------------------
module byte_stream_mix_hash (
  input  logic        clk,
  input  logic        rst_n,
  // key byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key_byte,
  input  logic        in_has_byte,
  input  logic        in_last_item,
  // hash result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value,
  // byte order register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_big_endian_order
);

  // Byte order register. It is sampled by the front end when a job is
  // built (twelfth byte of a group or end of key), not per byte.
  logic           big_endian_order_r;

  // front end -> queue -> back end
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  bsmh_pkg::job_t push_job;
  bsmh_pkg::job_t head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_order_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      big_endian_order_r <= cfg_big_endian_order;
    end
  end

  // Intake: idle transactions (no byte, no end) only pass through the
  // handshake. An end transaction that also completes a group posts a
  // single job carrying both the mix and the finish.
  bsmh_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_byte      (in_key_byte),
    .in_has_byte      (in_has_byte),
    .in_last_item     (in_last_item),
    .big_endian_order (big_endian_order_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (push_job)
  );

  // Two jobs of slack: intake keeps running while the engine mixes the
  // previous group or waits on a stalled result.
  bsmh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Engine: packed words are added on pop, then mix and final rounds run one per
  // cycle; the last waits on a held hash. The output register parts engine and consumer.
  bsmh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

`ifndef ASSERT_OFF
  // front end never posts into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job posted into full queue");

  // engine never takes a job from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // a new hash never rises right after a pop; the final rounds sit between
  a_result_after_job: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(q_pop, 1))
    else $error("hash appeared without finish rounds");
`endif

endmodule

### rtl/bsmh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmh_front: byte intake
// Collects key bytes into a twelve-byte group and posts a job when a group
// fills or the key ends.
// ----------------------------------------------------------------------------
module bsmh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_key_byte,
  input  logic              in_has_byte,
  input  logic              in_last_item,
  input  logic              big_endian_order,
  input  logic              q_full,
  output logic              q_push,
  output bsmh_pkg::job_t    q_job
);

  logic [bsmh_pkg::GROUP_LEN-1:0][7:0] grp_r;
  logic [bsmh_pkg::GROUP_LEN-1:0][7:0] merged;
  logic [bsmh_pkg::POS_W-1:0]          pos_r;
  logic [bsmh_pkg::POS_W-1:0]          pos_nxt;
  logic                                accept;
  logic                                full_grp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign full_grp = in_has_byte && (pos_r == bsmh_pkg::POS_W'(bsmh_pkg::GROUP_LEN - 1));
  assign q_push   = accept && (full_grp || in_last_item);

  always_comb begin
    merged = grp_r;
    if (in_has_byte) begin
      merged[pos_r] = in_key_byte;
    end
  end

  always_comb begin
    q_job.bytes      = merged;
    q_job.count      = in_has_byte ? pos_r + 1'b1 : pos_r;
    q_job.do_mix     = full_grp;
    q_job.do_fin     = in_last_item;
    q_job.big_endian = big_endian_order;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (full_grp || in_last_item) begin
      pos_nxt = '0;
    end else if (in_has_byte) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_has_byte) begin
      grp_r[pos_r] <= in_key_byte;
    end
  end

endmodule

### rtl/bsmh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmh_queue: job queue
// Short register queue that decouples intake from the mixing engine.
// ----------------------------------------------------------------------------
module bsmh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bsmh_pkg::job_t push_job,
  input  logic           pop,
  output bsmh_pkg::job_t head_job,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (bsmh_pkg::QUEUE_DEPTH > 1) ? $clog2(bsmh_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bsmh_pkg::QUEUE_DEPTH + 1);

  bsmh_pkg::job_t   slot_r [bsmh_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(bsmh_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(bsmh_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/bsmh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmh_back: mixing engine
// Adds packed words, runs the mix and final rounds one per cycle, the last
// waiting on a full output register, and holds the hash in that register.
// ----------------------------------------------------------------------------
module bsmh_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  bsmh_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_hash_value
);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MIX,
    BK_FIN
  } bk_state_t;

  bk_state_t                     state_r;
  bsmh_pkg::words_t              words_r;
  logic [bsmh_pkg::STEP_W-1:0]   step_r;
  logic                          fin_pend_r;
  logic                          out_valid_r;
  logic [31:0]                   out_hash_r;
  bsmh_pkg::words_t              packed_w;
  bsmh_pkg::words_t              mixed_w;
  bsmh_pkg::words_t              final_w;
  logic                          fin_done;

  assign packed_w       = bsmh_pkg::pack_words(q_job);
  assign mixed_w        = bsmh_pkg::mix_step(words_r, step_r);
  assign final_w        = bsmh_pkg::final_step(words_r, step_r);
  assign q_pop          = (state_r == BK_IDLE) && !q_empty;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  // last final round can retire into the output register this cycle
  assign fin_done       = (state_r == BK_FIN) && (step_r == bsmh_pkg::FIN_LAST) &&
                          (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      words_r     <= bsmh_pkg::INIT_WORDS;
      step_r      <= '0;
      fin_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        BK_IDLE: begin
          if (!q_empty) begin
            words_r.a  <= words_r.a + packed_w.a;
            words_r.b  <= words_r.b + packed_w.b;
            words_r.c  <= words_r.c + packed_w.c;
            step_r     <= '0;
            fin_pend_r <= q_job.do_fin;
            state_r    <= q_job.do_mix ? BK_MIX : BK_FIN;
          end
        end
        BK_MIX: begin
          words_r <= mixed_w;
          if (step_r == bsmh_pkg::MIX_LAST) begin
            step_r  <= '0;
            state_r <= fin_pend_r ? BK_FIN : BK_IDLE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        BK_FIN: begin
          if (step_r != bsmh_pkg::FIN_LAST) begin
            words_r <= final_w;
            step_r  <= step_r + 1'b1;
          end else if (fin_done) begin
            // last round lands straight in the output register
            out_hash_r  <= final_w.c;
            words_r     <= bsmh_pkg::INIT_WORDS;
            step_r      <= '0;
            state_r     <= BK_IDLE;
          end
        end
        default: state_r <= BK_IDLE;
      endcase
    end
  end

endmodule
